>>> hdl/arq_retransmit_scheduler_defines.svh
// Assertion helpers shared by the checker.
`ifndef ARQ_RETRANSMIT_SCHEDULER_DEFINES_SVH
`define ARQ_RETRANSMIT_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define ARS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset.
`define ARS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ars_pkg.sv
`timescale 1ns / 1ps

package ars_pkg;

    // Packet slots tracked by the scheduler
    localparam int MAX_PACKETS = 64;

    // Item actions
    localparam logic ACTION_POLL = 1'b0;
    localparam logic ACTION_ACK  = 1'b1;

    // Acknowledgement status codes
    localparam logic [1:0] ACK_NONE      = 2'd0;
    localparam logic [1:0] ACK_ACCEPTED  = 2'd1;
    localparam logic [1:0] ACK_DUPLICATE = 2'd2;
    localparam logic [1:0] ACK_INVALID   = 2'd3;

    // Register select (byte address bit 2)
    localparam logic REG_PACKET_COUNT  = 1'b0;
    localparam logic REG_TIMEOUT_TICKS = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] now_time;
        logic [15:0] ack_seq;
    } in_item_t;

    typedef struct packed {
        logic       send_now;
        logic [5:0] send_index;
        logic       all_done;
        logic [1:0] ack_status;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SETTLE1,
        ST_SETTLE2,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_ack;
    } dp_stat_t;

endpackage

>>> hdl/ars_scan.sv
`timescale 1ns / 1ps

module ars_scan (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [ars_pkg::MAX_PACKETS-1:0] acked,
    output logic [7:0]                      first_open
);

    localparam int MAX_PACKETS = ars_pkg::MAX_PACKETS;
    localparam int SCAN_N = (MAX_PACKETS < 128) ? MAX_PACKETS : 128;
    localparam int NGRP   = (SCAN_N + 7) / 8;

    logic [NGRP*8-1:0] bits;
    logic [NGRP-1:0]   grp_open_reg;
    logic [NGRP-1:0]   grp_open_next;
    logic [2:0]        grp_low_reg  [NGRP];
    logic [2:0]        grp_low_next [NGRP];
    logic [7:0]        first_reg;
    logic [7:0]        first_next;

    // Pad the scanned range to whole groups; padding counts as acknowledged
    genvar gi;
    generate
        for (gi = 0; gi < NGRP * 8; gi++)
        begin : g_pad
            if (gi < SCAN_N)
            begin : g_real
                assign bits[gi] = acked[gi];
            end
            else
            begin : g_fill
                assign bits[gi] = 1'b1;
            end
        end
    endgenerate

    // Stage one: lowest open bit inside each group of eight
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_open_next[g] = ~&bits[g*8 +: 8];
            grp_low_next[g]  = 3'd0;
            for (int b = 7; b >= 0; b--)
            begin
                if (!bits[g*8 + b])
                begin
                    grp_low_next[g] = 3'(b);
                end
            end
        end
    end

    // Stage two: lowest open group
    always_comb
    begin
        first_next = 8'(SCAN_N);
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (grp_open_reg[g])
            begin
                first_next = 8'(g * 8) + {5'd0, grp_low_reg[g]};
            end
        end
    end

    // Hold a reset image that matches an all-clear acknowledged vector
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_open_reg <= '1;
            first_reg    <= 8'd0;
            for (int g = 0; g < NGRP; g++)
            begin
                grp_low_reg[g] <= 3'd0;
            end
        end
        else
        begin
            grp_open_reg <= grp_open_next;
            first_reg    <= first_next;
            for (int g = 0; g < NGRP; g++)
            begin
                grp_low_reg[g] <= grp_low_next[g];
            end
        end
    end

    assign first_open = first_reg;

endmodule

>>> hdl/ars_datapath.sv
`timescale 1ns / 1ps

module ars_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  ars_pkg::ctrl_cmd_t cmd,
    input  ars_pkg::in_item_t  item_in,
    input  logic [6:0]        packet_count,
    input  logic [15:0]       timeout_ticks,
    output ars_pkg::dp_stat_t  stat,
    output ars_pkg::out_item_t result
);

    localparam int MAX_PACKETS = ars_pkg::MAX_PACKETS;
    localparam int AW    = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
    localparam int CAP_N = (MAX_PACKETS < 127) ? MAX_PACKETS : 127;

    ars_pkg::in_item_t  item_reg;
    ars_pkg::out_item_t result_reg;

    logic [MAX_PACKETS-1:0] acked_reg;
    logic [MAX_PACKETS-1:0] acked_next;
    logic [MAX_PACKETS-1:0] sent_reg;
    logic [MAX_PACKETS-1:0] sent_next;
    logic [31:0]            stamp_mem [MAX_PACKETS];
    logic [31:0]            stamp_rd_reg;
    logic [6:0]             cursor_reg;
    logic [6:0]             cursor_next;
    logic                   res_send_reg;
    logic                   res_send_next;
    logic [5:0]             res_index_reg;
    logic [5:0]             res_index_next;
    logic [1:0]             res_status_reg;
    logic [1:0]             res_status_next;

    logic [7:0]    first_open;
    logic [6:0]    n_eff;
    logic          has_open;
    logic [AW-1:0] c_idx;
    logic [AW-1:0] s_idx;
    logic          c_live;
    logic [31:0]   elapsed;
    logic          due;
    logic          do_send;
    logic          seq_valid;

    ars_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .acked     (acked_reg),
        .first_open(first_open)
    );

    // Effective count and cursor checks
    assign n_eff     = (packet_count > 7'(CAP_N)) ? 7'(CAP_N) : packet_count;
    assign has_open  = first_open < {1'b0, n_eff};
    assign c_idx     = AW'(cursor_reg);
    assign s_idx     = AW'(item_reg.ack_seq);
    assign c_live    = (cursor_reg < n_eff) && !acked_reg[c_idx];
    assign elapsed   = item_reg.now_time - stamp_rd_reg;
    assign due       = !sent_reg[c_idx] || (elapsed > {16'd0, timeout_ticks});
    assign seq_valid = item_reg.ack_seq < 16'(MAX_PACKETS);
    assign do_send   = cmd.exec && (item_reg.action == ars_pkg::ACTION_POLL)
                       && has_open && c_live && due;

    // Execute one poll or acknowledgement
    always_comb
    begin
        acked_next      = acked_reg;
        sent_next       = sent_reg;
        cursor_next     = cursor_reg;
        res_send_next   = res_send_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        if (cmd.exec)
        begin
            res_send_next   = 1'b0;
            res_index_next  = 6'd0;
            res_status_next = ars_pkg::ACK_NONE;
            if (item_reg.action == ars_pkg::ACTION_ACK)
            begin
                if (!seq_valid)
                begin
                    res_status_next = ars_pkg::ACK_INVALID;
                end
                else if (acked_reg[s_idx])
                begin
                    res_status_next = ars_pkg::ACK_DUPLICATE;
                end
                else
                begin
                    acked_next[s_idx] = 1'b1;
                    res_status_next   = ars_pkg::ACK_ACCEPTED;
                end
            end
            else if (has_open)
            begin
                if (c_live)
                begin
                    if (due)
                    begin
                        sent_next[c_idx] = 1'b1;
                        res_send_next    = 1'b1;
                        res_index_next   = cursor_reg[5:0];
                    end
                    cursor_next = cursor_reg + 7'd1;
                end
                else
                begin
                    cursor_next = first_open[6:0];
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acked_reg  <= '0;
            sent_reg   <= '0;
            cursor_reg <= 7'd0;
        end
        else
        begin
            acked_reg  <= acked_next;
            sent_reg   <= sent_next;
            cursor_reg <= cursor_next;
        end
    end

    // Send-time store: read at the cursor every cycle, write on a send
    always_ff @(posedge clk)
    begin
        stamp_rd_reg <= stamp_mem[c_idx];
        if (do_send)
        begin
            stamp_mem[c_idx] <= item_reg.now_time;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        res_send_reg   <= res_send_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        if (cmd.capture)
        begin
            item_reg <= item_in;
        end
        if (cmd.load_out)
        begin
            result_reg.send_now   <= res_send_reg;
            result_reg.send_index <= res_index_reg;
            result_reg.all_done   <= !has_open;
            result_reg.ack_status <= res_status_reg;
        end
    end

    assign stat.is_ack = (item_reg.action == ars_pkg::ACTION_ACK);
    assign result      = result_reg;

endmodule

>>> hdl/ars_ctrl.sv
`timescale 1ns / 1ps

module ars_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    output logic               result_valid,
    input  logic               result_ready,
    input  ars_pkg::dp_stat_t  stat,
    output ars_pkg::ctrl_cmd_t cmd
);

    ars_pkg::state_t state_reg;
    ars_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ars_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Sequence one item: execute, let the scan settle after an ack, deliver
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        item_ready   = 1'b0;
        case (state_reg)
            ars_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ars_pkg::ST_EXEC;
                end
            end
            ars_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.is_ack ? ars_pkg::ST_SETTLE1 : ars_pkg::ST_FINISH;
            end
            ars_pkg::ST_SETTLE1:
            begin
                state_next = ars_pkg::ST_SETTLE2;
            end
            ars_pkg::ST_SETTLE2:
            begin
                state_next = ars_pkg::ST_FINISH;
            end
            ars_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ars_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ars_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

>>> hdl/arq_retransmit_scheduler.sv
`timescale 1ns / 1ps
// A poll passes through the EXEC and FINISH states before its result is registered; an ack
// also passes through SETTLE1 and SETTLE2 so that the two-stage lowest-unacknowledged-packet
// scan sees its new bit. Only one item is in work at a time.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n, asynchronous, active low) clears acknowledged and sent bits, the
// cursor and the scan; packet_count resets to 0 and timeout_ticks to 1.
module arq_retransmit_scheduler (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  ars_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output ars_pkg::out_item_t result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [6:0]         packet_count_reg;
    logic [15:0]        timeout_ticks_reg;
    logic               cfg_write;
    ars_pkg::ctrl_cmd_t cmd;
    ars_pkg::dp_stat_t  stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_count_reg  <= 7'd0;
            timeout_ticks_reg <= 16'd1;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                ars_pkg::REG_PACKET_COUNT:  packet_count_reg  <= pwdata[6:0];
                ars_pkg::REG_TIMEOUT_TICKS: timeout_ticks_reg <= pwdata[15:0];
                default:                    packet_count_reg  <= packet_count_reg;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (paddr[2])
            ars_pkg::REG_PACKET_COUNT:  prdata = {25'd0, packet_count_reg};
            ars_pkg::REG_TIMEOUT_TICKS: prdata = {16'd0, timeout_ticks_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    ars_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    ars_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item_in      (item),
        .packet_count (packet_count_reg),
        .timeout_ticks(timeout_ticks_reg),
        .stat         (stat),
        .result       (result)
    );

endmodule

>>> hdl/ars_checker.sv
`timescale 1ns / 1ps
`include "arq_retransmit_scheduler_defines.svh"

module ars_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input logic               result_valid,
    input logic               result_ready,
    input ars_pkg::out_item_t result
);

    // A waiting result holds until its transfer
    `ARS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result dropped or changed while stalled")

    // One item at a time: input closes right after a transfer
    `ARS_ASSERT_NEXT(a_one_in_flight, item_valid && item_ready, !item_ready, "item taken while another is in work")

    // A send comes from a poll with open packets
    `ARS_ASSERT_NOW(a_send_is_poll, result_valid && result.send_now, result.ack_status == ars_pkg::ACK_NONE && !result.all_done, "send reported with ack status or done")

    // No index without a send
    `ARS_ASSERT_NOW(a_idle_index, result_valid && !result.send_now, result.send_index == 6'd0, "send index set without a send")

endmodule

bind arq_retransmit_scheduler ars_checker u_ars_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
);

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int          PKT_SLOTS     = ars_pkg::MAX_PACKETS;
    localparam int          CLK_PERIOD    = 12;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          LONG_HOLD     = 300;
    localparam int unsigned RUN_LIMIT_NS  = 3_000_000;

    localparam logic [2:0] ADDR_PACKET_COUNT  = {ars_pkg::REG_PACKET_COUNT, 2'b00};
    localparam logic [2:0] ADDR_TIMEOUT_TICKS = {ars_pkg::REG_TIMEOUT_TICKS, 2'b00};

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_ready;
    ars_pkg::in_item_t  item         = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    ars_pkg::out_item_t result;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [2:0]         paddr        = '0;
    logic [31:0]        pwdata       = '0;
    logic [31:0]        prdata;
    logic               pready;

    bit          tx_burst      = 1'b0;
    bit          rx_burst      = 1'b0;
    int unsigned results_taken = 0;

    arq_retransmit_scheduler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Tracks per-packet ack/sent/stamp state and the cursor, queues the
    // scheduling decision each transfer should produce.
    class arq_tracker;
        bit [6:0]           packet_count;
        bit [15:0]          timeout_ticks;
        bit                 acked [PKT_SLOTS];
        bit                 sent [PKT_SLOTS];
        bit [31:0]          stamp [PKT_SLOTS];
        bit [6:0]           cursor;
        ars_pkg::out_item_t pending_results[$];
        int unsigned        mismatches;
        int unsigned        checked;
        int unsigned        polls;
        int unsigned        sends;
        int unsigned        resends;
        int unsigned        relocations;
        int unsigned        done_polls;
        int unsigned        ack_tally [4];

        function new();
            packet_count  = 7'd0;
            timeout_ticks = 16'd1;
            cursor        = 7'd0;
        endfunction

        function void set_config(bit [6:0] count, bit [15:0] tmo);
            packet_count  = count;
            timeout_ticks = tmo;
        endfunction

        function int unsigned live_count();
            return (packet_count > PKT_SLOTS) ? PKT_SLOTS : packet_count;
        endfunction

        // Lowest unacknowledged packet below the live count, else the count.
        function int unsigned lowest_open();
            int unsigned n;
            n = live_count();
            for (int unsigned i = 0; i < n; i++)
                if (!acked[i])
                    return i;
            return n;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void take_item(ars_pkg::in_item_t it);
            ars_pkg::out_item_t want;
            int unsigned        n;
            int unsigned        c;
            bit [31:0]          elapsed;
            n    = live_count();
            want = '0;
            want.ack_status = ars_pkg::ACK_NONE;
            if (it.action == ars_pkg::ACTION_ACK)
            begin
                // Mark the packet unless out of range or already marked
                if (it.ack_seq >= PKT_SLOTS)
                    want.ack_status = ars_pkg::ACK_INVALID;
                else if (acked[it.ack_seq])
                    want.ack_status = ars_pkg::ACK_DUPLICATE;
                else
                begin
                    acked[it.ack_seq] = 1'b1;
                    want.ack_status   = ars_pkg::ACK_ACCEPTED;
                end
                ack_tally[want.ack_status]++;
            end
            else
            begin
                polls++;
                if (lowest_open() < n)
                begin
                    c = cursor;
                    if (c < n && !acked[c])
                    begin
                        // Send if never sent or timeout passed (mod 2^32)
                        elapsed = it.now_time - stamp[c];
                        if (!sent[c] || elapsed > {16'd0, timeout_ticks})
                        begin
                            if (sent[c])
                                resends++;
                            sent[c]         = 1'b1;
                            stamp[c]        = it.now_time;
                            want.send_now   = 1'b1;
                            want.send_index = 6'(c);
                            sends++;
                        end
                        cursor = 7'(c + 1);
                    end
                    else
                    begin
                        // Jump to the lowest open packet, no send this time
                        cursor = 7'(lowest_open());
                        relocations++;
                    end
                end
            end
            want.all_done = (lowest_open() >= n);
            if (want.all_done && it.action == ars_pkg::ACTION_POLL)
                done_polls++;
            pending_results.push_back(want);
        endfunction

        task report(string what);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $time, what);
        endtask

        task check_result(ars_pkg::out_item_t got);
            ars_pkg::out_item_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result 0x%03h with nothing pending", got));
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.send_now !== want.send_now)
                report($sformatf("send_now got %b want %b", got.send_now, want.send_now));
            if (got.send_index !== want.send_index)
                report($sformatf("send_index got %0d want %0d",
                                 got.send_index, want.send_index));
            if (got.all_done !== want.all_done)
                report($sformatf("all_done got %b want %b", got.all_done, want.all_done));
            if (got.ack_status !== want.ack_status)
                report($sformatf("ack_status got %0d want %0d",
                                 got.ack_status, want.ack_status));
        endtask
    endclass

    arq_tracker tracker = new();

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

    // Drain results with random stalls and a few long hold-offs
    initial
    begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                tracker.check_result(result);
                results_taken++;
                if ($urandom_range(0, 39) == 0)
                    rx_burst = !rx_burst;
                if (results_taken % 400 == 150)
                    hold_left = LONG_HOLD;
                else
                    hold_left = rx_burst ? 0 : $urandom_range(0, 13);
            end
            else if (hold_left > 0)
            begin
                hold_left--;
            end
            result_ready <= (hold_left == 0);
        end
    end

    // Offer one item after a random gap; hold it until the transfer
    task automatic send_item(input ars_pkg::in_item_t it);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        tracker.take_item(it);
    endtask

    task automatic poll_at(input logic [31:0] t);
        ars_pkg::in_item_t it;
        it.action   = ars_pkg::ACTION_POLL;
        it.now_time = t;
        it.ack_seq  = 16'($urandom());
        send_item(it);
    endtask

    task automatic ack_of(input logic [15:0] seq);
        ars_pkg::in_item_t it;
        it.action   = ars_pkg::ACTION_ACK;
        it.now_time = $urandom();
        it.ack_seq  = seq;
        send_item(it);
    endtask

    // Drop valid, wait for every result, then let the pipeline drain
    task automatic settle();
        item_valid <= 1'b0;
        while (tracker.pending() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reg(input logic [2:0] addr, input logic [31:0] mask,
                             input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if ((prdata & mask) !== want)
            tracker.report($sformatf("register 0x%0h read 0x%0h want 0x%0h",
                                     addr, prdata & mask, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [6:0] count, input logic [15:0] tmo);
        write_reg(ADDR_PACKET_COUNT, {25'd0, count});
        write_reg(ADDR_TIMEOUT_TICKS, {16'd0, tmo});
        tracker.set_config(count, tmo);
        check_reg(ADDR_PACKET_COUNT, 32'h7F, {25'd0, count});
        check_reg(ADDR_TIMEOUT_TICKS, 32'hFFFF, {16'd0, tmo});
    endtask

    // Mostly polls on an advancing clock, acks mostly aimed at live packets
    task automatic random_phase(input logic [6:0] count, input logic [15:0] tmo,
                                input int unsigned items);
        ars_pkg::in_item_t it;
        int unsigned       live;
        int unsigned       span;
        int unsigned       pick;
        bit [31:0]         clock_now;
        configure(count, tmo);
        live      = (count > PKT_SLOTS) ? PKT_SLOTS : count;
        span      = (2 * tmo) / (live + 1) + 1;
        clock_now = $urandom();
        repeat (items)
        begin
            if ($urandom_range(0, 49) == 0)
                tx_burst = !tx_burst;
            it.now_time = $urandom();
            it.ack_seq  = 16'($urandom());
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                it.action = ars_pkg::ACTION_ACK;
                pick = $urandom_range(0, 9);
                if (pick < 7 && live > 0)
                    it.ack_seq = 16'($urandom_range(0, live - 1));
                else if (pick < 9)
                    it.ack_seq = 16'($urandom_range(0, PKT_SLOTS - 1));
            end
            else
            begin
                it.action = ars_pkg::ACTION_POLL;
                if ($urandom_range(0, 39) == 0)
                    clock_now = $urandom();
                else
                    clock_now += $urandom_range(0, span);
                it.now_time = clock_now;
            end
            send_item(it);
        end
        settle();
    endtask

    initial
    begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values, empty transfer, invalid, beyond-count and duplicate acks
        check_reg(ADDR_PACKET_COUNT, 32'h7F, 32'd0);
        check_reg(ADDR_TIMEOUT_TICKS, 32'hFFFF, 32'd1);
        poll_at(32'h1234_5678);
        ack_of(16'hFFFF);
        ack_of(16'd64);
        ack_of(16'd63);
        ack_of(16'd63);
        settle();

        // Count above capacity, zero timeout
        configure(7'd127, 16'd0);
        poll_at(32'hFFFF_FFF0);
        poll_at(32'hFFFF_FFF0);
        ack_of(16'd0);
        settle();

        // Cursor relocation past the count and onto an acknowledged packet, duplicate ack
        configure(7'd2, 16'd20);
        poll_at(32'h0000_0000);
        poll_at(32'h0000_0004);
        poll_at(32'h0000_0004);
        poll_at(32'h0000_0005);
        ack_of(16'd1);
        poll_at(32'h0000_0006);
        ack_of(16'd1);
        settle();

        // Largest timeout: exactly at the limit holds, one past it resends
        configure(7'd4, 16'hFFFF);
        poll_at(32'h0000_0000);
        poll_at(32'h0000_0000);
        poll_at(32'h0000_0000);
        poll_at(32'h0000_FFFF);
        poll_at(32'h0000_FFFF);
        poll_at(32'h0000_FFFF);
        poll_at(32'h0001_0000);
        settle();

        // Random phases over growing counts and mixed timeouts
        random_phase(7'd3, 16'd0, 60);
        random_phase(7'd12, 16'hFFFF, 100);
        random_phase(7'd24, 16'd5, 150);
        random_phase(7'd40, 16'd300, 200);
        random_phase(7'd64, 16'd1, 220);
        random_phase(7'd127, 16'h8000, 220);
        random_phase(7'd0, 16'hFFFF, 40);
        random_phase(7'd127, 16'd17, 100);

        $display("Covered %0d polls: %0d sends, %0d retransmissions, %0d relocations, %0d done",
                 tracker.polls, tracker.sends, tracker.resends, tracker.relocations,
                 tracker.done_polls);
        $display("Acks: %0d accepted, %0d duplicate, %0d invalid; %0d results compared",
                 tracker.ack_tally[ars_pkg::ACK_ACCEPTED],
                 tracker.ack_tally[ars_pkg::ACK_DUPLICATE],
                 tracker.ack_tally[ars_pkg::ACK_INVALID], tracker.checked);
        if (tracker.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
